FILE: sv/mpool_pkg.sv
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared lane layout and default sizes for the 2x2 max pooling stream.
// ----------------------------------------------------------------------------
`default_nettype none

package mpool_pkg;

  // fixed port layout: four 64-bit words of four 16-bit lanes each
  localparam int WORD_W = 64;
  localparam int LANES  = 16;
  localparam int LANE_W = 16;
  localparam int BUS_W  = LANES * LANE_W;

  // default feature map geometry
  localparam int MAP_SIZE_DEF   = 11;
  localparam int CHANNELS_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 16;

endpackage

`default_nettype wire

FILE: sv/mpool_max4.sv
// ----------------------------------------------------------------------------
// mpool_max4
// Per-channel signed maximum of four pixels, packed into the 16-bit lane bus.
// ----------------------------------------------------------------------------
`default_nettype none

module mpool_max4
  import mpool_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic [CHANNELS*DATA_WIDTH-1:0] pix_a,
  input  wire logic [CHANNELS*DATA_WIDTH-1:0] pix_b,
  input  wire logic [CHANNELS*DATA_WIDTH-1:0] pix_c,
  input  wire logic [CHANNELS*DATA_WIDTH-1:0] pix_d,
  output logic      [BUS_W-1:0]               pooled
);

  genvar ch;
  generate
    for (ch = 0; ch < LANES; ch++) begin : g_lane
      if (ch < CHANNELS) begin : g_used
        logic signed [DATA_WIDTH-1:0] a, b, c, d, m_ab, m_cd, m;
        assign a    = pix_a[ch*DATA_WIDTH +: DATA_WIDTH];
        assign b    = pix_b[ch*DATA_WIDTH +: DATA_WIDTH];
        assign c    = pix_c[ch*DATA_WIDTH +: DATA_WIDTH];
        assign d    = pix_d[ch*DATA_WIDTH +: DATA_WIDTH];
        assign m_ab = (a > b) ? a : b;
        assign m_cd = (c > d) ? c : d;
        assign m    = (m_ab > m_cd) ? m_ab : m_cd;
        // sign extend into the 16-bit lane
        assign pooled[ch*LANE_W +: LANE_W] = LANE_W'(m);
      end else begin : g_unused
        assign pooled[ch*LANE_W +: LANE_W] = '0;
      end
    end
  endgenerate

endmodule

`default_nettype wire

FILE: sv/max_pool_2x2_stream.sv
// ----------------------------------------------------------------------------
// max_pool_2x2_stream
// Streaming 2x2 stride-2 max pooling over a square feature map in raster
// order, with the even rows kept as column pairs in a line memory.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid/in_ready   | in_pixel_word_0..3, 16-bit lanes
//   out     | out_valid/out_ready | out_pooled_word_0..3, out_frame_last
//
// one input beat per cycle unless a stalled output holds one back; a pooled
// beat appears in the output register the cycle after the odd-row, odd-column
// beat that completes its window. the line memory read for a window is issued
// on the preceding even-column beat, so its registered data is there in time.
// reset clears the row/column counters and the output valid only.
// a stalled output holds back only beats that would produce a result.
//
`default_nettype none

module max_pool_2x2_stream
  import mpool_pkg::*;
#(
  parameter int MAP_SIZE   = MAP_SIZE_DEF,
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_pixel_word_0,
  input  wire logic [WORD_W-1:0] in_pixel_word_1,
  input  wire logic [WORD_W-1:0] in_pixel_word_2,
  input  wire logic [WORD_W-1:0] in_pixel_word_3,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [WORD_W-1:0] out_pooled_word_0,
  output logic      [WORD_W-1:0] out_pooled_word_1,
  output logic      [WORD_W-1:0] out_pooled_word_2,
  output logic      [WORD_W-1:0] out_pooled_word_3,
  output logic                   out_frame_last
);

  localparam int CW       = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int PAIRS    = MAP_SIZE / 2;
  localparam int AW       = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PW       = CHANNELS * DATA_WIDTH;
  localparam int LAST_ODD = (MAP_SIZE / 2) * 2 - 1;

  logic [BUS_W-1:0] in_bus;
  logic [PW-1:0]    pix;

  assign in_bus = {in_pixel_word_3, in_pixel_word_2, in_pixel_word_1, in_pixel_word_0};

  genvar ch;
  generate
    for (ch = 0; ch < CHANNELS; ch++) begin : g_unpack
      assign pix[ch*DATA_WIDTH +: DATA_WIDTH] = in_bus[ch*LANE_W +: DATA_WIDTH];
    end
  endgenerate

  // position counters
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          col_wrap;

  logic in_fire, emit;
  logic out_valid_r, out_valid_nxt;

  assign emit     = row_r[0] & col_r[0];
  assign in_ready = !emit || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign col_wrap = (col_r == CW'(MAP_SIZE - 1));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fire) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (row_r == CW'(MAP_SIZE - 1)) ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // even-column pixel of the current row, on even and odd rows alike
  logic [PW-1:0] hold_r;

  always_ff @(posedge clk) begin
    if (in_fire && !col_r[0]) begin
      hold_r <= pix;
    end
  end

  // line memory: one entry per column pair, {odd column, even column}
  logic [2*PW-1:0] line_mem [PAIRS];
  logic [2*PW-1:0] mem_q;
  logic [AW-1:0]   mem_addr;
  logic            mem_wr, mem_rd;

  assign mem_addr = AW'(col_r >> 1);
  assign mem_wr   = in_fire && !row_r[0] && col_r[0];
  // skip the unpaired last column of an odd-sized map
  assign mem_rd   = in_fire && row_r[0] && !col_r[0] && !col_wrap;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      line_mem[mem_addr] <= {pix, hold_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_q <= line_mem[mem_addr];
    end
  end

  logic [BUS_W-1:0] pooled;

  mpool_max4 #(
    .CHANNELS   (CHANNELS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_max4 (
    .pix_a  (mem_q[PW-1:0]),
    .pix_b  (mem_q[2*PW-1:PW]),
    .pix_c  (hold_r),
    .pix_d  (pix),
    .pooled (pooled)
  );

  // output register
  logic [BUS_W-1:0] out_bus_r;
  logic             out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_bus_r  <= pooled;
      out_last_r <= (row_r == CW'(LAST_ODD)) && (col_r == CW'(LAST_ODD));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pooled_word_0 = out_bus_r[0*WORD_W +: WORD_W];
  assign out_pooled_word_1 = out_bus_r[1*WORD_W +: WORD_W];
  assign out_pooled_word_2 = out_bus_r[2*WORD_W +: WORD_W];
  assign out_pooled_word_3 = out_bus_r[3*WORD_W +: WORD_W];
  assign out_frame_last    = out_last_r;

endmodule

`default_nettype wire

FILE: test/max_pool_2x2_stream_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_pool_2x2_stream_tb
// Self-checking bench for the 2x2 stride-2 max pooling stream. Whole frames
// of pixels are pushed in raster order through a bursty driver while the
// receiver stalls on a pattern of its own, with two long hold-offs.
// Every pooled beat is checked against a window predictor kept in the bench.
// ----------------------------------------------------------------------------

module max_pool_2x2_stream_tb
  import mpool_pkg::*;
();

  localparam int MAP          = MAP_SIZE_DEF;
  localparam int CHN          = CHANNELS_DEF;
  localparam int DW           = DATA_WIDTH_DEF;
  localparam int LAST_ODD     = (MAP / 2) * 2 - 1;
  localparam int FRAMES       = 13;
  localparam int TOTAL_PIXELS = FRAMES * MAP * MAP;
  localparam int DIRECTED     = 2 * MAP;
  localparam int MAX_REPORTS  = 10;

  typedef logic [BUS_W-1:0] lanes_t;
  typedef struct packed {
    lanes_t lanes;
    logic   frame_end;
  } pooled_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PATTERN} rdy_mode_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   out_ready = 1'b0;
  lanes_t in_lanes  = '0;

  wire              in_ready;
  wire              out_valid;
  wire              out_frame_last;
  wire [WORD_W-1:0] out_word_0;
  wire [WORD_W-1:0] out_word_1;
  wire [WORD_W-1:0] out_word_2;
  wire [WORD_W-1:0] out_word_3;

  max_pool_2x2_stream u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_word_0   (in_lanes[0*WORD_W +: WORD_W]),
    .in_pixel_word_1   (in_lanes[1*WORD_W +: WORD_W]),
    .in_pixel_word_2   (in_lanes[2*WORD_W +: WORD_W]),
    .in_pixel_word_3   (in_lanes[3*WORD_W +: WORD_W]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pooled_word_0 (out_word_0),
    .out_pooled_word_1 (out_word_1),
    .out_pooled_word_2 (out_word_2),
    .out_pooled_word_3 (out_word_3),
    .out_frame_last    (out_frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pixels to send and pooled beats still owed by the block
  lanes_t  pixel_q [$];
  pooled_t pooled_q [$];

  // window predictor state
  int line_mem [MAP][CHN];
  int held_px [CHN];
  int row_pos = 0;
  int col_pos = 0;

  int pixels_taken = 0;
  int beats_seen   = 0;
  int mismatch_cnt = 0;
  int hold_cycles  = 0;

  function automatic int lane_value(lanes_t px, int ch);
    int x;
    x = int'(px[ch*LANE_W +: LANE_W]) & ((1 << DW) - 1);
    if (x[DW-1]) x = x - (1 << DW);
    return x;
  endfunction

  function automatic int max_of(int a, int b);
    return (a > b) ? a : b;
  endfunction

  task automatic predict_window(input lanes_t px);
    pooled_t beat;
    int      m;
    if (row_pos % 2 == 0) begin
      for (int ch = 0; ch < CHN; ch++) line_mem[col_pos][ch] = lane_value(px, ch);
    end else if (col_pos % 2 == 0) begin
      for (int ch = 0; ch < CHN; ch++) held_px[ch] = lane_value(px, ch);
    end else begin
      beat = '0;
      for (int ch = 0; ch < CHN; ch++) begin
        m = max_of(max_of(line_mem[col_pos-1][ch], held_px[ch]),
                   max_of(line_mem[col_pos][ch], lane_value(px, ch)));
        beat.lanes[ch*LANE_W +: LANE_W] = m[LANE_W-1:0];
      end
      beat.frame_end = (row_pos == LAST_ODD) && (col_pos == LAST_ODD);
      pooled_q.push_back(beat);
    end
    col_pos++;
    if (col_pos >= MAP) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= MAP) row_pos = 0;
    end
  endtask

  // first two rows: extremes, ties and sign flips placed so each window mixes them
  function automatic lanes_t directed_pixel(int idx);
    case (idx)
      0, 8, 11, 12, 13, 14, 17, 19, 20: return {LANES{16'h8000}};
      1, 10, 21:                        return {LANES{16'h7fff}};
      2:                                return '0;
      3, 9, 18:                         return {LANES{16'hffff}};
      4, 15:                            return {(LANES/2){16'h7fff, 16'h8000}};
      5, 16:                            return {(LANES/2){16'h8000, 16'h7fff}};
      6:                                return {LANES{16'haaaa}};
      7:                                return {LANES{16'h5555}};
      default:                          return '0;
    endcase
  endfunction

  function automatic lanes_t random_pixel();
    lanes_t           px;
    logic [LANE_W-1:0] shared;
    int               base;
    int               v;
    px     = '0;
    shared = LANE_W'($urandom);
    base   = $urandom_range(0, 16) - 8;
    case ($urandom_range(0, 3))
      0: begin
        for (int i = 0; i < BUS_W / 32; i++) px[i*32 +: 32] = $urandom;
      end
      1: begin
        for (int ch = 0; ch < LANES; ch++) begin
          case ($urandom_range(0, 5))
            0:       px[ch*LANE_W +: LANE_W] = 16'h8000;
            1:       px[ch*LANE_W +: LANE_W] = 16'h7fff;
            2:       px[ch*LANE_W +: LANE_W] = 16'h0000;
            3:       px[ch*LANE_W +: LANE_W] = 16'hffff;
            4:       px[ch*LANE_W +: LANE_W] = 16'h8001;
            default: px[ch*LANE_W +: LANE_W] = 16'h7ffe;
          endcase
        end
      end
      2: begin
        // values close to zero on both sides so windows compare near-equal
        for (int ch = 0; ch < LANES; ch++) begin
          v = base + $urandom_range(0, 6) - 3;
          px[ch*LANE_W +: LANE_W] = v[LANE_W-1:0];
        end
      end
      default: begin
        for (int ch = 0; ch < LANES; ch++)
          px[ch*LANE_W +: LANE_W] = $urandom_range(0, 2) != 0 ? shared : LANE_W'($urandom);
      end
    endcase
    return px;
  endfunction

  // driver: bursts of beats with idle gaps
  int drive_idx  = 0;
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    logic taken;
    logic show;
    if (rst_n) begin
      taken = in_valid && (pixels_taken > drive_idx);
      if (taken) drive_idx++;
      show = 1'b0;
      if (in_valid && !taken) begin
        show = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (drive_idx < pixel_q.size()) begin
        show = 1'b1;
        in_lanes <= pixel_q[drive_idx];
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left--;
        end
      end
      in_valid <= show;
    end
  end

  // receiver: rotating stall patterns plus two long hold-offs
  int rcv_cycle = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    rdy_mode_t mode;
    if (rst_n) begin
      rcv_cycle++;
      mode = rdy_mode_t'((rcv_cycle / 150) % 4);
      if (hold_left > 0) begin
        hold_left--;
        hold_cycles++;
        out_ready <= 1'b0;
      end else if (rcv_cycle == 500 || rcv_cycle == 1500) begin
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS:  out_ready <= 1'b1;
          RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
          RDY_MOSTLY:  out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= (rcv_cycle % 8) > 2;
        endcase
      end
    end
  end

  // monitor: check pooled beats, then feed accepted pixels to the predictor
  always @(posedge clk) begin
    pooled_t got;
    pooled_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_word_3, out_word_2, out_word_1, out_word_0, out_frame_last};
        if (pooled_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] pooled beat %0d with nothing pending: %h last=%b",
                     $realtime, beats_seen, got.lanes, got.frame_end);
        end else begin
          want = pooled_q.pop_front();
          if (got.lanes !== want.lanes || got.frame_end !== want.frame_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("[%0t] pooled beat %0d mismatch", $realtime, beats_seen);
              $display("  want %h last=%b", want.lanes, want.frame_end);
              $display("  got  %h last=%b", got.lanes, got.frame_end);
            end
          end
        end
        beats_seen++;
      end
      if (in_valid && in_ready) begin
        predict_window(in_lanes);
        pixels_taken++;
      end
    end
  end

  initial begin
    for (int i = 0; i < TOTAL_PIXELS; i++)
      pixel_q.push_back(i < DIRECTED ? directed_pixel(i) : random_pixel());
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pixels_taken < TOTAL_PIXELS || pooled_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("covered %0d frames of %0dx%0d pixels, %0d pooled beats checked, %0d mismatches",
             FRAMES, MAP, MAP, beats_seen, mismatch_cnt);
    $display("receiver held off for %0d cycles in long stretches", hold_cycles);
    if (mismatch_cnt == 0 && pooled_q.size() == 0) begin
      $display("max_pool_2x2_stream regression: pass");
    end else begin
      $display("max_pool_2x2_stream regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d of %0d pixels taken, %0d beats pending",
             pixels_taken, TOTAL_PIXELS, pooled_q.size());
    $display("max_pool_2x2_stream regression: fail");
    $finish;
  end

endmodule
